// ===== sv/triangle_screen_proximity_pick_macros.svh =====
// Assertion macros used by the port checker file.
`ifndef TRIANGLE_SCREEN_PROXIMITY_PICK_MACROS_SVH
`define TRIANGLE_SCREEN_PROXIMITY_PICK_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define TSPP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tspp assertion failed");

// Next-cycle implication, disabled while rst is high.
`define TSPP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tspp assertion failed");

`endif

// ===== sv/tspp_pkg.sv =====
package tspp_pkg;

   localparam int COORD_FRAC_BITS    = 4;
   localparam int VERTS_PER_TRIANGLE = 3;
   localparam int COORD_W            = 16;
   localparam int ID_W               = 20;
   localparam int PROD_W             = 32;
   localparam int CLIP_W             = 34;
   localparam int LIN_W              = 48;
   localparam int MAG_W              = 50;
   localparam int HALF_W             = MAG_W / 2;
   localparam int SQ_W               = 2 * MAG_W;
   localparam int CMP_W              = SQ_W + 8;
   localparam int PIPE_DEPTH         = 7;
   localparam int CSR_IDX_W          = 4;
   localparam int CSR_DATA_W         = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_ZERO   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_ONE    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_TWO    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_THREE  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR     = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS     = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH      = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT     = 4'd7;

   // Rows zero, one and three of the matrix; the z row never matters.
   typedef struct packed {
      logic [2:0][63:0] rows;
      logic [11:0]      cur_x;
      logic [11:0]      cur_y;
      logic [15:0]      radius;
      logic [12:0]      width;
      logic [12:0]      height;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vertex_type;

   typedef struct packed {
      logic [ID_W-1:0]                         id;
      vertex_type [VERTS_PER_TRIANGLE-1:0]     verts;
   } tri_type;

endpackage

// ===== sv/triangle_screen_proximity_pick.sv =====
// Triangle screen proximity pick.
// The req channel takes one triangle per transaction: an id and three vertices
// in signed Q12.4. Each vertex goes through the programmed matrix, is divided
// by w and mapped to pixels; if any vertex lies strictly inside the pick
// radius around the cursor, the triangle appears on the rsp channel unchanged.
// Triangles with no near vertex produce no rsp transaction.
// The csr channel writes the matrix rows, cursor, radius and screen size; it is
// always ready and should only be used while no triangle is in flight.
// Throughput is one triangle per cycle unless the output stalls. The accepting
// edge loads the first of seven pipeline stages in each vertex lane, whose
// wide squaring is cut into partial products, and the output register takes
// the last stage's result.
// When rsp_ready is low with a result waiting, the whole pipeline holds and
// req_ready falls; nothing is lost or repeated. Synchronous reset empties the
// pipeline and restores identity matrix, cursor 0, radius 10.0, 1024 x 768.
module triangle_screen_proximity_pick (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [tspp_pkg::ID_W-1:0]             req_triangle_id,
   input  logic signed [tspp_pkg::COORD_W-1:0]   req_v0_x,
   input  logic signed [tspp_pkg::COORD_W-1:0]   req_v0_y,
   input  logic signed [tspp_pkg::COORD_W-1:0]   req_v0_z,
   input  logic signed [tspp_pkg::COORD_W-1:0]   req_v1_x,
   input  logic signed [tspp_pkg::COORD_W-1:0]   req_v1_y,
   input  logic signed [tspp_pkg::COORD_W-1:0]   req_v1_z,
   input  logic signed [tspp_pkg::COORD_W-1:0]   req_v2_x,
   input  logic signed [tspp_pkg::COORD_W-1:0]   req_v2_y,
   input  logic signed [tspp_pkg::COORD_W-1:0]   req_v2_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [tspp_pkg::ID_W-1:0]             rsp_picked_id,
   output logic signed [tspp_pkg::COORD_W-1:0]   rsp_out_v0_x,
   output logic signed [tspp_pkg::COORD_W-1:0]   rsp_out_v0_y,
   output logic signed [tspp_pkg::COORD_W-1:0]   rsp_out_v0_z,
   output logic signed [tspp_pkg::COORD_W-1:0]   rsp_out_v1_x,
   output logic signed [tspp_pkg::COORD_W-1:0]   rsp_out_v1_y,
   output logic signed [tspp_pkg::COORD_W-1:0]   rsp_out_v1_z,
   output logic signed [tspp_pkg::COORD_W-1:0]   rsp_out_v2_x,
   output logic signed [tspp_pkg::COORD_W-1:0]   rsp_out_v2_y,
   output logic signed [tspp_pkg::COORD_W-1:0]   rsp_out_v2_z,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tspp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tspp_pkg::CSR_DATA_W-1:0]       csr_data
);
   import tspp_pkg::*;

   cfg_type                     cfg;
   tri_type                     tri_in;
   tri_type                     tri_ff [PIPE_DEPTH];
   logic [PIPE_DEPTH-1:0]       vld_ff;
   tri_type                     rsp_tri_ff;
   logic                        rsp_valid_ff;
   logic [VERTS_PER_TRIANGLE-1:0] near;
   logic                        adv;

   tspp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign tri_in.id          = req_triangle_id;
   assign tri_in.verts[0].x  = req_v0_x;
   assign tri_in.verts[0].y  = req_v0_y;
   assign tri_in.verts[0].z  = req_v0_z;
   assign tri_in.verts[1].x  = req_v1_x;
   assign tri_in.verts[1].y  = req_v1_y;
   assign tri_in.verts[1].z  = req_v1_z;
   assign tri_in.verts[2].x  = req_v2_x;
   assign tri_in.verts[2].y  = req_v2_y;
   assign tri_in.verts[2].z  = req_v2_z;

   // The pipeline moves as a whole whenever the output register can take a value.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   for (genvar k = 0; k < VERTS_PER_TRIANGLE; k++) begin : g_lane
      tspp_vertex_lane u_lane (
         .clock (clock),
         .en    (adv),
         .cfg   (cfg),
         .vert  (tri_in.verts[k]),
         .near  (near[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1] && (near != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tri_ff[0] <= tri_in;
         for (int i = 1; i < PIPE_DEPTH; i++) begin
            tri_ff[i] <= tri_ff[i-1];
         end
         rsp_tri_ff <= tri_ff[PIPE_DEPTH-1];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_picked_id = rsp_tri_ff.id;
   assign rsp_out_v0_x  = rsp_tri_ff.verts[0].x;
   assign rsp_out_v0_y  = rsp_tri_ff.verts[0].y;
   assign rsp_out_v0_z  = rsp_tri_ff.verts[0].z;
   assign rsp_out_v1_x  = rsp_tri_ff.verts[1].x;
   assign rsp_out_v1_y  = rsp_tri_ff.verts[1].y;
   assign rsp_out_v1_z  = rsp_tri_ff.verts[1].z;
   assign rsp_out_v2_x  = rsp_tri_ff.verts[2].x;
   assign rsp_out_v2_y  = rsp_tri_ff.verts[2].y;
   assign rsp_out_v2_z  = rsp_tri_ff.verts[2].z;

endmodule

// ===== sv/tspp_csr.sv =====
module tspp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tspp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tspp_pkg::CSR_DATA_W-1:0]   csr_data,
   output tspp_pkg::cfg_type                 cfg
);
   import tspp_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Writes to the z row are accepted and have no effect.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows[0] <= 64'd256;
         cfg_ff.rows[1] <= 64'd16777216;
         cfg_ff.rows[2] <= 64'd72057594037927936;
         cfg_ff.cur_x   <= '0;
         cfg_ff.cur_y   <= '0;
         cfg_ff.radius  <= 16'd160;
         cfg_ff.width   <= 13'd1024;
         cfg_ff.height  <= 13'd768;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROW_ZERO:  cfg_ff.rows[0] <= csr_data;
            CSR_ROW_ONE:   cfg_ff.rows[1] <= csr_data;
            CSR_ROW_TWO:   ;
            CSR_ROW_THREE: cfg_ff.rows[2] <= csr_data;
            CSR_CURSOR: begin
               cfg_ff.cur_x <= csr_data[11:0];
               cfg_ff.cur_y <= csr_data[23:12];
            end
            CSR_RADIUS:    cfg_ff.radius <= csr_data[15:0];
            CSR_WIDTH:     cfg_ff.width  <= csr_data[12:0];
            CSR_HEIGHT:    cfg_ff.height <= csr_data[12:0];
            default:       ;
         endcase
      end
   end

endmodule

// ===== sv/tspp_vertex_lane.sv =====
module tspp_vertex_lane (
   input  logic                 clock,
   input  logic                 en,
   input  tspp_pkg::cfg_type    cfg,
   input  tspp_pkg::vertex_type vert,
   output logic                 near
);
   import tspp_pkg::*;

   logic signed [3:0][COORD_W-1:0]      hv;
   logic signed [PROD_W-1:0]            p_ff [3][4];
   logic signed [PROD_W-1:0]            p_in [3][4];
   logic signed [CLIP_W-1:0]            c_ff [3];
   logic signed [CLIP_W-1:0]            c_in [3];
   logic signed [CLIP_W:0]              xs, ys;
   logic signed [LIN_W-1:0]             a_ff, b_ff, c2_ff, d_ff;
   logic signed [LIN_W-1:0]             a_in, b_in, c2_in, d_in;
   logic [MAG_W-1:0]                    r_ff, r_in;
   logic                                wpos3_ff, wpos4_ff, wpos5_ff, wpos6_ff;
   logic signed [LIN_W-1:0]             ex, ey;
   logic [MAG_W-1:0]                    mx_ff, my_ff, mr_ff;
   logic [MAG_W-1:0]                    mx_in, my_in, mr_in;
   logic [2:0][MAG_W-1:0]               pp_ff [3];
   logic [2:0][MAG_W-1:0]               pp_in [3];
   logic [SQ_W-1:0]                     sq_ff [3];
   logic [SQ_W-1:0]                     sq_in [3];
   logic                                near_ff, near_in;
   logic [CMP_W-1:0]                    lhs, rhs;

   assign hv[0] = vert.x;
   assign hv[1] = vert.y;
   assign hv[2] = vert.z;
   assign hv[3] = COORD_W'(1 << COORD_FRAC_BITS);

   // Stage 1: coefficient products.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            p_in[r][c] = PROD_W'($signed(cfg.rows[r][16*c +: 16]))
                       * PROD_W'($signed(hv[c]));
         end
      end
   end

   // Stage 2: clip x, y and w.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         c_in[r] = CLIP_W'(p_ff[r][0]) + CLIP_W'(p_ff[r][1])
                 + CLIP_W'(p_ff[r][2]) + CLIP_W'(p_ff[r][3]);
      end
   end

   // Stage 3: viewport and cursor terms, radius scaled by w.
   always_comb begin
      xs    = (CLIP_W+1)'(c_ff[0]) + (CLIP_W+1)'(c_ff[2]);
      ys    = (CLIP_W+1)'(c_ff[2]) - (CLIP_W+1)'(c_ff[1]);
      a_in  = LIN_W'(xs) * LIN_W'($signed({1'b0, cfg.width}));
      b_in  = LIN_W'(c_ff[2]) * LIN_W'($signed({1'b0, cfg.cur_x}));
      c2_in = LIN_W'(ys) * LIN_W'($signed({1'b0, cfg.height}));
      d_in  = LIN_W'(c_ff[2]) * LIN_W'($signed({1'b0, cfg.cur_y}));
      r_in  = MAG_W'(c_ff[2][CLIP_W-2:0]) * MAG_W'(cfg.radius);
   end

   // Stage 4: pixel offsets from the cursor, as magnitudes.
   always_comb begin
      ex    = a_ff - (b_ff <<< 1);
      ey    = c2_ff - (d_ff <<< 1);
      mx_in = MAG_W'(ex[LIN_W-1] ? -ex : ex);
      my_in = MAG_W'(ey[LIN_W-1] ? -ey : ey);
      mr_in = r_ff << 1;
   end

   // Stage 5: squares split into half-width partial products.
   always_comb begin
      logic [MAG_W-1:0] m [3];
      m[0] = mx_ff;
      m[1] = my_ff;
      m[2] = mr_ff;
      for (int i = 0; i < 3; i++) begin
         pp_in[i][2] = MAG_W'(m[i][MAG_W-1:HALF_W]) * MAG_W'(m[i][MAG_W-1:HALF_W]);
         pp_in[i][1] = MAG_W'(m[i][MAG_W-1:HALF_W]) * MAG_W'(m[i][HALF_W-1:0]);
         pp_in[i][0] = MAG_W'(m[i][HALF_W-1:0]) * MAG_W'(m[i][HALF_W-1:0]);
      end
   end

   // Stage 6: assemble the three squares.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = {pp_ff[i][2], {MAG_W{1'b0}}}
                  + (SQ_W'(pp_ff[i][1]) << (HALF_W + 1))
                  + SQ_W'(pp_ff[i][0]);
      end
   end

   // Stage 7: the offsets were left unscaled by the radius step of 16, hence the shift.
   always_comb begin
      lhs     = {(CMP_W-8)'(sq_ff[0]) + (CMP_W-8)'(sq_ff[1]), 8'b0};
      rhs     = CMP_W'(sq_ff[2]);
      near_in = wpos6_ff && (lhs < rhs);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff     <= p_in;
         c_ff     <= c_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         c2_ff    <= c2_in;
         d_ff     <= d_in;
         r_ff     <= r_in;
         wpos3_ff <= !c_ff[2][CLIP_W-1] && (c_ff[2] != '0);
         mx_ff    <= mx_in;
         my_ff    <= my_in;
         mr_ff    <= mr_in;
         wpos4_ff <= wpos3_ff;
         pp_ff    <= pp_in;
         wpos5_ff <= wpos4_ff;
         sq_ff    <= sq_in;
         wpos6_ff <= wpos5_ff;
         near_ff  <= near_in;
      end
   end

   assign near = near_ff;

endmodule

// ===== sv/tspp_checker.sv =====
`include "triangle_screen_proximity_pick_macros.svh"

module tspp_port_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [tspp_pkg::ID_W-1:0]  rsp_picked_id
);

   // A waiting result keeps its transaction on the port.
   `TSPP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `TSPP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_picked_id))
   // The input side only stalls while a result is blocked at the output.
   `TSPP_ASSERT_NOW(a_ready_link, clock, reset, req_valid || !req_valid,
                    req_ready == (!rsp_valid || rsp_ready))
   // No result survives a reset.
   `TSPP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind triangle_screen_proximity_pick tspp_port_checker u_tspp_checker (.*);

// ===== test/tspp_checker.sv =====
`timescale 1ns / 100ps

module tspp_checker
   import tspp_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [ID_W-1:0]             req_triangle_id,
   input  logic signed [COORD_W-1:0]   req_v0_x,
   input  logic signed [COORD_W-1:0]   req_v0_y,
   input  logic signed [COORD_W-1:0]   req_v0_z,
   input  logic signed [COORD_W-1:0]   req_v1_x,
   input  logic signed [COORD_W-1:0]   req_v1_y,
   input  logic signed [COORD_W-1:0]   req_v1_z,
   input  logic signed [COORD_W-1:0]   req_v2_x,
   input  logic signed [COORD_W-1:0]   req_v2_y,
   input  logic signed [COORD_W-1:0]   req_v2_z,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [ID_W-1:0]             rsp_picked_id,
   input  logic signed [COORD_W-1:0]   rsp_out_v0_x,
   input  logic signed [COORD_W-1:0]   rsp_out_v0_y,
   input  logic signed [COORD_W-1:0]   rsp_out_v0_z,
   input  logic signed [COORD_W-1:0]   rsp_out_v1_x,
   input  logic signed [COORD_W-1:0]   rsp_out_v1_y,
   input  logic signed [COORD_W-1:0]   rsp_out_v1_z,
   input  logic signed [COORD_W-1:0]   rsp_out_v2_x,
   input  logic signed [COORD_W-1:0]   rsp_out_v2_y,
   input  logic signed [COORD_W-1:0]   rsp_out_v2_z,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data,
   output int                          mismatch_count,
   output int                          pending_count
);

   typedef logic signed [127:0] wide_type;

   logic [63:0] mat_row [4];
   logic [23:0] cursor_reg;
   logic [15:0] radius_reg;
   logic [12:0] width_reg;
   logic [12:0] height_reg;
   tri_type     picked_queue [$];

   function automatic wide_type clip_coord(logic [63:0] row, vertex_type v);
      wide_type acc;
      wide_type coord [4];
      acc = 0;
      coord[0] = v.x;
      coord[1] = v.y;
      coord[2] = v.z;
      coord[3] = 1 << COORD_FRAC_BITS;
      for (int c = 0; c < 4; c++) begin
         acc += wide_type'($signed(row[16*c +: 16])) * coord[c];
      end
      return acc;
   endfunction

   // Exact rational form of the pixel distance test, so no rounding enters.
   function automatic bit vertex_in_reach(vertex_type v);
      wide_type cx, cy, w, ex, ey, rr, scr_w, scr_h, mx, my, rad;
      cx = clip_coord(mat_row[0], v);
      cy = clip_coord(mat_row[1], v);
      w  = clip_coord(mat_row[3], v);
      if (w <= 0) return 1'b0;
      scr_w = width_reg;
      scr_h = height_reg;
      mx    = cursor_reg[11:0];
      my    = cursor_reg[23:12];
      rad   = radius_reg;
      ex = ((cx + w) * scr_w - 2 * w * mx) * 16;
      ey = ((w - cy) * scr_h - 2 * w * my) * 16;
      rr = rad * 2 * w;
      return (ex * ex + ey * ey) < (rr * rr);
   endfunction

   function automatic bit triangle_picked(tri_type t);
      bit hit;
      hit = 1'b0;
      for (int k = 0; k < VERTS_PER_TRIANGLE; k++) begin
         if (vertex_in_reach(t.verts[k])) hit = 1'b1;
      end
      return hit;
   endfunction

   task automatic note_mismatch(string what, longint expd, longint got);
      if (mismatch_count < 10) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, expd, got);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      tri_type inp, outp, expd;
      if (reset) begin
         mat_row[0] <= 64'd256;
         mat_row[1] <= 64'd16777216;
         mat_row[2] <= 64'd1099511627776;
         mat_row[3] <= 64'd72057594037927936;
         cursor_reg <= '0;
         radius_reg <= 16'd160;
         width_reg  <= 13'd1024;
         height_reg <= 13'd768;
         picked_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROW_ZERO:  mat_row[0] <= csr_data;
               CSR_ROW_ONE:   mat_row[1] <= csr_data;
               CSR_ROW_TWO:   mat_row[2] <= csr_data;
               CSR_ROW_THREE: mat_row[3] <= csr_data;
               CSR_CURSOR:    cursor_reg <= csr_data[23:0];
               CSR_RADIUS:    radius_reg <= csr_data[15:0];
               CSR_WIDTH:     width_reg  <= csr_data[12:0];
               CSR_HEIGHT:    height_reg <= csr_data[12:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            inp.id = req_triangle_id;
            inp.verts[0] = '{req_v0_x, req_v0_y, req_v0_z};
            inp.verts[1] = '{req_v1_x, req_v1_y, req_v1_z};
            inp.verts[2] = '{req_v2_x, req_v2_y, req_v2_z};
            if (triangle_picked(inp)) picked_queue = {picked_queue, inp};
         end
         if (rsp_valid && rsp_ready) begin
            outp.id = rsp_picked_id;
            outp.verts[0] = '{rsp_out_v0_x, rsp_out_v0_y, rsp_out_v0_z};
            outp.verts[1] = '{rsp_out_v1_x, rsp_out_v1_y, rsp_out_v1_z};
            outp.verts[2] = '{rsp_out_v2_x, rsp_out_v2_y, rsp_out_v2_z};
            if (picked_queue.size() == 0) begin
               note_mismatch("unexpected transaction, id", -1, outp.id);
            end else begin
               expd = picked_queue.pop_front();
               if (outp.id != expd.id) note_mismatch("picked_id", expd.id, outp.id);
               for (int k = 0; k < VERTS_PER_TRIANGLE; k++) begin
                  if (outp.verts[k].x != expd.verts[k].x)
                     note_mismatch($sformatf("v%0d_x", k), expd.verts[k].x,
                                   outp.verts[k].x);
                  if (outp.verts[k].y != expd.verts[k].y)
                     note_mismatch($sformatf("v%0d_y", k), expd.verts[k].y,
                                   outp.verts[k].y);
                  if (outp.verts[k].z != expd.verts[k].z)
                     note_mismatch($sformatf("v%0d_z", k), expd.verts[k].z,
                                   outp.verts[k].z);
               end
            end
         end
      end
   end

   initial mismatch_count = 0;
   assign pending_count = picked_queue.size();

endmodule

// ===== test/tb_triangle_screen_proximity_pick.sv =====
`timescale 1ns / 100ps

module tb_triangle_screen_proximity_pick;
   import tspp_pkg::*;

   // An index that names no register at all.
   localparam logic [CSR_IDX_W-1:0] CSR_NONE = '1;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [ID_W-1:0]             req_triangle_id = '0;
   logic signed [COORD_W-1:0]   req_v0_x = '0, req_v0_y = '0, req_v0_z = '0;
   logic signed [COORD_W-1:0]   req_v1_x = '0, req_v1_y = '0, req_v1_z = '0;
   logic signed [COORD_W-1:0]   req_v2_x = '0, req_v2_y = '0, req_v2_z = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [ID_W-1:0]             rsp_picked_id;
   logic signed [COORD_W-1:0]   rsp_out_v0_x, rsp_out_v0_y, rsp_out_v0_z;
   logic signed [COORD_W-1:0]   rsp_out_v1_x, rsp_out_v1_y, rsp_out_v1_z;
   logic signed [COORD_W-1:0]   rsp_out_v2_x, rsp_out_v2_y, rsp_out_v2_z;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_data = '0;
   int                          mismatch_count;
   int                          pending_count;
   bit                          no_idle = 1'b0;

   // Screen mapping of the current random phase, used to aim vertices.
   int scale_s, trans_t, scr_w, scr_h, cur_x, cur_y;
   bit aim_ok;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   triangle_screen_proximity_pick i_dut (.*);
   tspp_checker i_checker (.*);

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // The result side may drop rsp_ready before each transaction, except in phases run without idle.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Triangles that give no result may still be in the pipeline, hence the tail.
   task automatic wait_quiet();
      while (pending_count != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic send_triangle(tri_type t);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_triangle_id = t.id;
      {req_v0_x, req_v0_y, req_v0_z} = t.verts[0];
      {req_v1_x, req_v1_y, req_v1_z} = t.verts[1];
      {req_v2_x, req_v2_y, req_v2_z} = t.verts[2];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_flat(int id, int x, int y, int z);
      tri_type t;
      t.id = ID_W'(id);
      for (int k = 0; k < VERTS_PER_TRIANGLE; k++)
         t.verts[k] = '{COORD_W'(x), COORD_W'(y), COORD_W'(z)};
      send_triangle(t);
   endtask

   function automatic logic signed [15:0] clamp16(int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return 16'(v);
   endfunction

   function automatic vertex_type rand_vertex(int span, bit noise, bit aim);
      vertex_type v;
      int nx, ny;
      v.z = 16'($urandom());
      if (noise) begin
         v.x = 16'($urandom());
         v.y = 16'($urandom());
      end else if (aim) begin
         // Invert the screen mapping for a point close to the cursor.
         nx = ((2 * cur_x - scr_w) * 4096) / scr_w - trans_t * 16;
         ny = ((scr_h - 2 * cur_y) * 4096) / scr_h - trans_t * 16;
         v.x = clamp16(nx / scale_s + $urandom_range(0, 4) - 2);
         v.y = clamp16(ny / scale_s + $urandom_range(0, 4) - 2);
      end else begin
         v.x = clamp16($urandom_range(0, 2 * span) - span);
         v.y = clamp16($urandom_range(0, 2 * span) - span);
      end
      return v;
   endfunction

   task automatic random_phase(int phase, int count);
      tri_type t;
      int span, tz, hit_k;
      bit noisy;
      wait_quiet();
      scale_s = $urandom_range(1, 8);
      trans_t = $urandom_range(0, 16) - 8;
      tz      = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) - 2 : 0;
      aim_ok  = (tz == 0);
      scr_w   = $urandom_range(64, 4096);
      scr_h   = $urandom_range(64, 4096);
      cur_x   = $urandom_range(0, (scr_w > 4095) ? 4095 : scr_w);
      cur_y   = $urandom_range(0, (scr_h > 4095) ? 4095 : scr_h);
      write_reg(CSR_ROW_ZERO, {16'(trans_t), 16'd0, 16'd0, 16'(scale_s)});
      write_reg(CSR_ROW_ONE, {16'(trans_t), 16'd0, 16'(scale_s), 16'd0});
      write_reg(CSR_ROW_TWO, {$urandom(), $urandom()});
      // A negative w term puts vertices behind the eye in one phase, all of them when the z term is zero.
      write_reg(CSR_ROW_THREE, {(phase == 3) ? -16'sd256 : 16'sd256, 16'(tz), 32'd0});
      write_reg(CSR_CURSOR, 64'({12'(cur_y), 12'(cur_x)}));
      write_reg(CSR_RADIUS, 64'($urandom_range(160, 3200)));
      write_reg(CSR_WIDTH, 64'(scr_w));
      write_reg(CSR_HEIGHT, 64'(scr_h));
      no_idle = (phase % 4 == 0);
      span = (16 * 256 * 3) / (2 * scale_s);
      for (int n = 0; n < count; n++) begin
         noisy = ($urandom_range(0, 4) == 0);
         hit_k = (aim_ok && !noisy && $urandom_range(0, 2) != 0) ? $urandom_range(0, 2) : -1;
         t.id = ID_W'($urandom());
         for (int k = 0; k < VERTS_PER_TRIANGLE; k++)
            t.verts[k] = rand_vertex(span, noisy, k == hit_k);
         send_triangle(t);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: identity matrix, so x = -1 and y = +1 land on the cursor.
      send_flat(0, -16, 16, 0);
      send_flat(20'hFFFFF, -32768, -32768, -32768);
      send_flat(1, 32767, 32767, 32767);
      send_flat(2, 0, 0, 0);
      send_flat(3, -15, 15, -1);
      send_flat(4, 16, -16, 5);

      wait_quiet();
      write_reg(CSR_RADIUS, 64'd0);
      send_flat(5, -16, 16, 0);
      wait_quiet();
      write_reg(CSR_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
      send_flat(6, -16, 16, 0);

      // Extremes of every register, screen sizes out of range among them.
      wait_quiet();
      write_reg(CSR_ROW_ZERO, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_ROW_ONE, 64'h8000_8000_8000_8000);
      write_reg(CSR_ROW_TWO, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_ROW_THREE, 64'h7FFF_7FFF_7FFF_7FFF);
      write_reg(CSR_CURSOR, 64'hFF_FFFF);
      write_reg(CSR_RADIUS, 64'hFFFF);
      write_reg(CSR_WIDTH, 64'd0);
      write_reg(CSR_HEIGHT, 64'h1FFF);
      send_flat(7, 32767, -32768, 32767);
      send_flat(8, -32768, 32767, -32768);
      send_flat(9, 0, 0, 0);
      send_flat(10, 1, -1, 0);

      wait_quiet();
      write_reg(CSR_ROW_ZERO, 64'h0000_0000_0000_7FFF);
      write_reg(CSR_ROW_ONE, 64'h0000_0000_8000_0000);
      write_reg(CSR_ROW_THREE, 64'h0001_0000_0000_0000);
      write_reg(CSR_CURSOR, 64'd0);
      write_reg(CSR_WIDTH, 64'd4096);
      write_reg(CSR_HEIGHT, 64'd1);
      send_flat(11, 0, 0, 0);
      send_flat(12, -1, 1, 0);
      send_flat(13, 32767, 32767, 0);
      send_flat(14, -32768, -32768, 0);

      for (int p = 0; p < 14; p++) random_phase(p, 50);

      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tspp_pkg.sv
sv/tspp_csr.sv
sv/tspp_vertex_lane.sv
sv/triangle_screen_proximity_pick.sv
sv/tspp_checker.sv
test/tspp_checker.sv
test/tb_triangle_screen_proximity_pick.sv
